FILE: rtl/ax25_header_parser_core_assert.svh
// Assertion macros for the AX.25 header parser.
`ifndef AX25_HEADER_PARSER_CORE_ASSERT_SVH
`define AX25_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define AX25HP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ax25hp assertion failed");

// Condition implies consequence in the next cycle.
`define AX25HP_ASSERT_NXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("ax25hp assertion failed");

`else

`define AX25HP_ASSERT(lbl, clk, rst_n, prop)
`define AX25HP_ASSERT_NXT(lbl, clk, rst_n, cond, cons)

`endif

`endif

FILE: rtl/ax25hp_pkg.sv
// Shared types and constants of the AX.25 header parser.
`default_nettype none

package ax25hp_pkg;

  localparam int MAX_DIGIPEATERS = 7;
  localparam int CALL_CHARS      = 6;
  localparam int CALL_W          = 8 * CALL_CHARS;

  localparam logic [6:0] CHAR_SPACE = 7'h20;

  localparam logic       KIND_ADDR = 1'b0;
  localparam logic       KIND_HDR  = 1'b1;

  localparam logic [1:0] ROLE_DEST = 2'd0;
  localparam logic [1:0] ROLE_SRC  = 2'd1;
  localparam logic [1:0] ROLE_DIGI = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        role;
    logic [2:0]        digi_index;
    logic [CALL_W-1:0] callsign;
    logic [3:0]        ssid;
    logic              repeated_flag;
    logic              last_flag;
    logic [7:0]        ctrl;
    logic [7:0]        pid;
    logic [2:0]        digi_count;
    logic              header_done;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ax25_header_parser_core.sv
// Top level of the AX.25 address header parser.
//
//   channel | signals                      | direction
//   in      | in_valid/in_ready, 2 fields  | byte stream in
//   out     | out_valid/out_ready, 11 flds | decoded fields out
//
// One byte per cycle while the result is not stalled; a byte goes through the input register,
// then is decoded into the result register.
// Parse state advances only when the input register moves into the result stage.
// A stalled result holds the stage; one more byte waits in the input register.
// Synchronous active-low reset empties both stages and returns to the address phase.
`default_nettype none

module ax25_header_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [1:0]       out_role,
  output logic [2:0]       out_digi_index,
  output logic [47:0]      out_callsign,
  output logic [3:0]       out_ssid,
  output logic             out_repeated_flag,
  output logic             out_last_flag,
  output logic [7:0]       out_ctrl,
  output logic [7:0]       out_pid,
  output logic [2:0]       out_digi_count,
  output logic             out_header_done
);
  import ax25hp_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  adv;
  logic  fire;
  logic  emit;
  res_t  res;
  res_t  out_res;

  assign in_item.data_byte   = in_data_byte;
  assign in_item.frame_start = in_frame_start;
  assign fire                = s1_valid && adv;

  ax25hp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ax25hp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .emit  (emit),
    .res   (res)
  );

  ax25hp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_role          = out_res.role;
  assign out_digi_index    = out_res.digi_index;
  assign out_callsign      = out_res.callsign;
  assign out_ssid          = out_res.ssid;
  assign out_repeated_flag = out_res.repeated_flag;
  assign out_last_flag     = out_res.last_flag;
  assign out_ctrl          = out_res.ctrl;
  assign out_pid           = out_res.pid;
  assign out_digi_count    = out_res.digi_count;
  assign out_header_done   = out_res.header_done;

endmodule

`default_nettype wire

FILE: rtl/ax25hp_in_stage.sv
// Input register stage of the AX.25 header parser.
`default_nettype none

module ax25hp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ax25hp_pkg::item_t in_item,
  input  wire logic           adv,
  output logic                s1_valid,
  output ax25hp_pkg::item_t   s1_item
);
  import ax25hp_pkg::*;

  logic  s1_valid_r;
  item_t item_r;

  assign in_ready = !s1_valid_r || adv;
  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ax25hp_parse.sv
// Header parse state and per-byte decode of the AX.25 header parser.
`default_nettype none

`include "ax25_header_parser_core_assert.svh"

module ax25hp_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire ax25hp_pkg::item_t item,
  output logic                   emit,
  output ax25hp_pkg::res_t       res
);
  import ax25hp_pkg::*;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_CTRL = 2'd1,
    PH_PID  = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  localparam logic [3:0] MAX_DIGI = 4'(MAX_DIGIPEATERS);
  localparam logic [2:0] CHARS    = 3'(CALL_CHARS);

  phase_t            phase_r, phase_nxt, ph;
  logic [2:0]        bpos_r, bpos_nxt, bpos;
  logic [3:0]        aidx_r, aidx_nxt, aidx;
  logic [CALL_W-1:0] cs_r, cs_nxt, cs;
  logic [2:0]        cc_r, cc_nxt, cc;
  logic [7:0]        ctrl_r, ctrl_nxt, ctrl;

  logic [7:0] b;
  logic [6:0] x;
  logic [3:0] aidx_m1;
  logic [3:0] aidx_m2;
  logic [1:0] role;
  logic       last;
  logic       done;

  assign b       = item.data_byte;
  assign x       = b[7:1];
  assign last    = b[0];

  always_comb begin
    if (item.frame_start) begin
      ph   = PH_ADDR;
      bpos = '0;
      aidx = '0;
      cs   = '0;
      cc   = '0;
      ctrl = '0;
    end else begin
      ph   = phase_r;
      bpos = bpos_r;
      aidx = aidx_r;
      cs   = cs_r;
      cc   = cc_r;
      ctrl = ctrl_r;
    end
  end

  assign aidx_m1 = aidx - 4'd1;
  assign aidx_m2 = aidx - 4'd2;

  always_comb begin
    priority if (aidx == 4'd0) begin
      role = ROLE_DEST;
    end else if (aidx == 4'd1) begin
      role = ROLE_SRC;
    end else begin
      role = ROLE_DIGI;
    end
  end

  always_comb begin
    unique case (role)
      ROLE_DEST: done = 1'b0;
      ROLE_SRC:  done = last;
      default:   done = last || (aidx_m1 >= MAX_DIGI);
    endcase
  end

  always_comb begin
    phase_nxt = ph;
    bpos_nxt  = bpos;
    aidx_nxt  = aidx;
    cs_nxt    = cs;
    cc_nxt    = cc;
    ctrl_nxt  = ctrl;
    emit      = 1'b0;
    res       = '0;
    unique case (ph)
      PH_ADDR: begin
        if (bpos < CHARS) begin
          if (x != CHAR_SPACE && cc < CHARS) begin
            for (int i = 0; i < CALL_CHARS; i++) begin
              if (cc == 3'(CALL_CHARS - 1 - i)) begin
                cs_nxt[i*8 +: 8] = cs[i*8 +: 8] | {1'b0, x};
              end
            end
            cc_nxt = cc + 3'd1;
          end
          bpos_nxt = bpos + 3'd1;
        end else begin
          emit              = 1'b1;
          res.kind          = KIND_ADDR;
          res.role          = role;
          res.digi_index    = (role == ROLE_DIGI) ? aidx_m2[2:0] : 3'd0;
          res.callsign      = cs;
          res.ssid          = b[4:1];
          res.repeated_flag = b[7];
          res.last_flag     = last;
          bpos_nxt          = '0;
          cs_nxt            = '0;
          cc_nxt            = '0;
          if (done) begin
            phase_nxt = PH_CTRL;
          end else begin
            aidx_nxt = aidx + 4'd1;
          end
        end
      end
      PH_CTRL: begin
        ctrl_nxt  = b;
        phase_nxt = PH_PID;
      end
      PH_PID: begin
        emit            = 1'b1;
        res.kind        = KIND_HDR;
        res.ctrl        = ctrl;
        res.pid         = b;
        res.digi_count  = (aidx >= 4'd1) ? aidx_m1[2:0] : 3'd0;
        res.header_done = 1'b1;
        phase_nxt       = PH_BODY;
      end
      PH_BODY: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      bpos_r  <= '0;
      aidx_r  <= '0;
      cs_r    <= '0;
      cc_r    <= '0;
      ctrl_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      aidx_r  <= aidx_nxt;
      cs_r    <= cs_nxt;
      cc_r    <= cc_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  `AX25HP_ASSERT(a_cc_range, clk, rst_n, cc_r <= CHARS)
  `AX25HP_ASSERT(a_aidx_range, clk, rst_n, aidx_r <= MAX_DIGI + 4'd1)
  `AX25HP_ASSERT_NXT(a_hdr_to_body, clk, rst_n, fire && emit && res.kind == KIND_HDR,
                     phase_r == PH_BODY)
  `AX25HP_ASSERT_NXT(a_addr_restart, clk, rst_n, fire && emit && res.kind == KIND_ADDR,
                     bpos_r == 3'd0 && cc_r == 3'd0 && cs_r == '0)

endmodule

`default_nettype wire

FILE: rtl/ax25hp_out_reg.sv
// Result register of the AX.25 header parser.
`default_nettype none

module ax25hp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire ax25hp_pkg::res_t res,
  output logic                  adv,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ax25hp_pkg::res_t      out_res
);
  import ax25hp_pkg::*;

  logic out_valid_r;
  res_t res_r;

  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sim/ax25_header_parser_core_tb.sv
// Self-checking testbench for the AX.25 address header parser: directed and random byte streams.
`timescale 1ns / 100ps

module ax25_header_parser_core_tb;
  import ax25hp_pkg::*;

  localparam logic [1:0] P_ADDR = 2'd0;
  localparam logic [1:0] P_CTRL = 2'd1;
  localparam logic [1:0] P_PID  = 2'd2;
  localparam logic [1:0] P_BODY = 2'd3;

  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_BYTES = 1850;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       pin;
    res_t       res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [1:0]  out_role;
  logic [2:0]  out_digi_index;
  logic [47:0] out_callsign;
  logic [3:0]  out_ssid;
  logic        out_repeated_flag;
  logic        out_last_flag;
  logic [7:0]  out_ctrl;
  logic [7:0]  out_pid;
  logic [2:0]  out_digi_count;
  logic        out_header_done;

  ax25_header_parser_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_role          (out_role),
    .out_digi_index    (out_digi_index),
    .out_callsign      (out_callsign),
    .out_ssid          (out_ssid),
    .out_repeated_flag (out_repeated_flag),
    .out_last_flag     (out_last_flag),
    .out_ctrl          (out_ctrl),
    .out_pid           (out_pid),
    .out_digi_count    (out_digi_count),
    .out_header_done   (out_header_done)
  );

  // parser mirror
  logic [1:0]        ph;
  logic [2:0]        pos;
  logic [3:0]        addr_idx;
  logic [CALL_W-1:0] call_acc;
  logic [2:0]        nchar;
  logic [7:0]        ctrl_hold;

  row_t stim_q[$];
  res_t pending_res_q[$];
  int   mismatch_cnt = 0;
  int   idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_parser();
    ph        = P_ADDR;
    pos       = '0;
    addr_idx  = '0;
    call_acc  = '0;
    nchar     = '0;
    ctrl_hold = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic st, output bit got,
                             output res_t r);
    logic [6:0] x;
    logic       done;
    if (st) clear_parser();
    r   = '0;
    got = 1'b0;
    case (ph)
      P_ADDR: begin
        if (pos < CALL_CHARS) begin
          x = b[7:1];
          if (x != CHAR_SPACE && nchar < CALL_CHARS) begin
            call_acc[8*(CALL_CHARS-1-nchar) +: 8] = {1'b0, x};
            nchar = nchar + 3'd1;
          end
          pos = pos + 3'd1;
        end else begin
          got             = 1'b1;
          r.kind          = KIND_ADDR;
          r.role          = (addr_idx == 0) ? ROLE_DEST : (addr_idx == 1) ? ROLE_SRC : ROLE_DIGI;
          r.digi_index    = (r.role == ROLE_DIGI) ? 3'(addr_idx - 4'd2) : 3'd0;
          r.callsign      = call_acc;
          r.ssid          = b[4:1];
          r.repeated_flag = b[7];
          r.last_flag     = b[0];
          if (r.role == ROLE_DEST) done = 1'b0;
          else if (r.role == ROLE_SRC) done = b[0];
          else done = b[0] || (int'(addr_idx) - 1 >= MAX_DIGIPEATERS);
          pos      = '0;
          call_acc = '0;
          nchar    = '0;
          if (done) ph = P_CTRL;
          else addr_idx = addr_idx + 4'd1;
        end
      end
      P_CTRL: begin
        ctrl_hold = b;
        ph        = P_PID;
      end
      P_PID: begin
        got           = 1'b1;
        r.kind        = KIND_HDR;
        r.ctrl        = ctrl_hold;
        r.pid         = b;
        r.digi_count  = (addr_idx >= 1) ? 3'(addr_idx - 4'd1) : 3'd0;
        r.header_done = 1'b1;
        ph            = P_BODY;
      end
      default: ;
    endcase
  endtask

  function automatic res_t mk_res(logic kind, logic [1:0] role, logic [47:0] call,
                                  logic [3:0] ssid, logic rep, logic last, logic [7:0] ctrl,
                                  logic [7:0] pid, logic [2:0] cnt, logic done);
    return {kind, role, 3'd0, call, ssid, rep, last, ctrl, pid, cnt, done};
  endfunction

  function automatic string res_str(res_t r);
    return {$sformatf("kind=%0d role=%0d didx=%0d call=%012h ssid=%0d ",
                      r.kind, r.role, r.digi_index, r.callsign, r.ssid),
            $sformatf("rep=%0d last=%0d ctrl=%02h pid=%02h cnt=%0d done=%0d",
                      r.repeated_flag, r.last_flag, r.ctrl, r.pid, r.digi_count,
                      r.header_done)};
  endfunction

  task automatic tab(input logic [7:0] b, input logic st, input logic pin, input res_t r);
    stim_q.push_back({b, st, pin, r});
  endtask

  task automatic gen_frame(inout int counted);
    logic [7:0] fb[$];
    logic [7:0] b;
    int sel, nd, c, len, hdr_len;
    bit st0;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) tab(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
      counted += len;
      return;
    end
    nd = $urandom_range(0, MAX_DIGIPEATERS);
    st0 = (sel != 2);
    for (int f = 0; f < nd + 2; f++) begin
      for (int j = 0; j < 7; j++) begin
        b = 8'($urandom_range(0, 255));
        if (j < CALL_CHARS) begin
          c = $urandom_range(0, 9);
          if (c < 2) begin
            b[7:1] = CHAR_SPACE;
          end else if (c < 9) begin
            c = $urandom_range(0, 35);
            b[7:1] = (c < 26) ? 7'(65 + c) : 7'(22 + c);
          end
        end else begin
          if (f >= 1) b[0] = (f == nd + 1);
          if (f == MAX_DIGIPEATERS + 1) b[0] = 1'($urandom_range(0, 1));
        end
        fb.push_back(b);
      end
    end
    hdr_len = fb.size() + 2;
    repeat (2 + $urandom_range(0, 5)) fb.push_back(8'($urandom_range(0, 255)));
    len = (sel == 1) ? $urandom_range(1, hdr_len - 1) : fb.size();
    for (int i = 0; i < len; i++) tab(fb[i], (i == 0) ? st0 : 1'b0, 1'b0, '0);
    counted += len;
  endtask

  // stimulus and end of run
  initial begin : sender
    row_t rw;
    res_t r;
    bit   got;
    int   counted, gap, mode_left;
    bit   busy_mode;
    counted   = 0;
    mode_left = 0;
    busy_mode = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_frame_start <= 1'b0;
    clear_parser();

    // no start mark after reset; destination last flag set and ignored; zero char
    tab(8'hFF, 1'b0, 1'b0, '0);
    tab(8'h00, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h41, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'hFF, 1'b0, 1'b1, mk_res(KIND_ADDR, ROLE_DEST, 48'h7F0000000000, 4'hF, 1'b1, 1'b1,
                                  8'h00, 8'h00, 3'd0, 1'b0));
    // source cut short by a new frame
    tab(8'h86, 1'b0, 1'b0, '0);
    tab(8'hA2, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h82, 1'b1, 1'b0, '0);
    tab(8'hA0, 1'b0, 1'b0, '0);
    tab(8'hA4, 1'b0, 1'b0, '0);
    tab(8'hA6, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h60, 1'b0, 1'b1, mk_res(KIND_ADDR, ROLE_DEST, 48'h415052530000, 4'h0, 1'b0, 1'b0,
                                  8'h00, 8'h00, 3'd0, 1'b0));
    repeat (6) tab(8'h40, 1'b0, 1'b0, '0);
    tab(8'h9F, 1'b0, 1'b1, mk_res(KIND_ADDR, ROLE_SRC, 48'h0, 4'hF, 1'b1, 1'b1,
                                  8'h00, 8'h00, 3'd0, 1'b0));
    tab(8'h00, 1'b0, 1'b0, '0);
    tab(8'hFF, 1'b0, 1'b1, mk_res(KIND_HDR, ROLE_DEST, 48'h0, 4'h0, 1'b0, 1'b0,
                                  8'h00, 8'hFF, 3'd0, 1'b1));
    tab(8'h55, 1'b0, 1'b0, '0);

    while (counted < TARGET_BYTES) gen_frame(counted);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0) begin
      rw = stim_q.pop_front();
      if (mode_left == 0) begin
        busy_mode = $urandom_range(0, 2) != 0;
        mode_left = 40;
      end
      mode_left--;
      gap = busy_mode ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_data_byte   <= rw.b;
      in_frame_start <= rw.st;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      decode_byte(rw.b, rw.st, got, r);
      if (rw.pin) r = rw.res;
      if (got || rw.pin) pending_res_q.push_back(r);
    end
    in_valid <= 1'b0;

    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_res_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin : receiver
    int  hold, mode_left, taken;
    bit  busy_mode;
    mode_left = 0;
    taken     = 0;
    busy_mode = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        busy_mode = $urandom_range(0, 2) != 0;
        mode_left = 40;
      end
      mode_left--;
      hold = busy_mode ? $urandom_range(0, 16) : 0;
      if (taken == 150) hold = 300;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin : result_check
    res_t act, want;
    if (rst_n && out_valid && out_ready) begin
      act = {out_kind, out_role, out_digi_index, out_callsign, out_ssid, out_repeated_flag,
             out_last_flag, out_ctrl, out_pid, out_digi_count, out_header_done};
      if (pending_res_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR unexpected transaction: %s", res_str(act));
      end else begin
        want = pending_res_q.pop_front();
        if (act !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("ERROR exp %s", res_str(want));
            $display("      got %s", res_str(act));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
